FILE: design/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types, codes and sizes for the stable priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int CAPACITY = 16;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int OCC_W    = 5;

  localparam logic FUNC_ENQ = 1'b0;
  localparam logic FUNC_DEQ = 1'b1;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic       func;
    logic [7:0] proc_id;
    logic [7:0] prio;
  } req_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [7:0]       out_id;
    logic [7:0]       out_prio;
    logic [OCC_W-1:0] occupancy;
  } rsp_t;

  typedef struct packed {
    logic [7:0] proc_id;
    logic [7:0] prio;
  } entry_t;

  typedef struct packed {
    logic load;
    logic exec;
  } cmd_t;

endpackage

FILE: design/spq_ctrl.sv
// ----------------------------------------------------------------------------
// spq_ctrl
// Controller: takes one request at a time and issues the load and execute
// commands to the datapath, and owns the response valid flag.
// ----------------------------------------------------------------------------
module spq_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output spq_pkg::cmd_t cmd
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_BUSY = 1'b1;

  logic state;
  logic state_next;
  logic rsp_valid_next;

  assign req_ready = (state == S_IDLE);

  always_comb begin
    state_next     = state;
    rsp_valid_next = rsp_valid && !rsp_ready;
    cmd.load       = 1'b0;
    cmd.exec       = 1'b0;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.load   = 1'b1;
          state_next = S_BUSY;
        end
      end
      S_BUSY: begin
        if (!rsp_valid || rsp_ready) begin
          cmd.exec       = 1'b1;
          rsp_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      rsp_valid <= rsp_valid_next;
    end
  end

endmodule

FILE: design/spq_datapath.sv
// ----------------------------------------------------------------------------
// spq_datapath
// Sorted row of entry registers with parallel compare, the fill count, the
// request holding register and the response register.
// ----------------------------------------------------------------------------
module spq_datapath (
  input  logic           clk,
  input  logic           rst,
  input  spq_pkg::cmd_t  cmd,
  input  spq_pkg::req_t  req,
  output spq_pkg::rsp_t  rsp
);

  localparam int CAP = spq_pkg::CAPACITY;

  spq_pkg::req_t               op;
  spq_pkg::entry_t             cells [CAP];
  spq_pkg::entry_t             enq_next [CAP];
  spq_pkg::entry_t             deq_next [CAP];
  spq_pkg::entry_t             prev_cell [CAP];
  spq_pkg::entry_t             new_entry;
  logic [spq_pkg::CNT_W-1:0]   count;
  logic [CAP-1:0]              ge;
  logic [CAP-1:0]              prev_ge;
  logic                        full;
  logic                        empty;

  assign new_entry = '{proc_id: op.proc_id, prio: op.prio};
  assign full      = (count == spq_pkg::CNT_W'(CAP));
  assign empty     = (count == '0);

  // Entries that stay in front of the new one form a prefix of the row.
  always_comb begin
    for (int i = 0; i < CAP; i++) begin
      ge[i] = (spq_pkg::CNT_W'(i) < count) && (cells[i].prio >= op.prio);
    end
  end

  assign prev_ge = {ge[CAP-2:0], 1'b1};

  always_comb begin
    prev_cell[0] = new_entry;
    for (int i = 1; i < CAP; i++) begin
      prev_cell[i] = cells[i-1];
    end
  end

  always_comb begin
    for (int i = 0; i < CAP; i++) begin
      if (ge[i]) begin
        enq_next[i] = cells[i];
      end else if (prev_ge[i]) begin
        enq_next[i] = new_entry;
      end else begin
        enq_next[i] = prev_cell[i];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < CAP - 1; i++) begin
      deq_next[i] = cells[i+1];
    end
    deq_next[CAP-1] = cells[CAP-1];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op <= req;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      if (op.func == spq_pkg::FUNC_ENQ && !full) begin
        for (int i = 0; i < CAP; i++) begin
          cells[i] <= enq_next[i];
        end
      end else if (op.func == spq_pkg::FUNC_DEQ && !empty) begin
        for (int i = 0; i < CAP; i++) begin
          cells[i] <= deq_next[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.exec) begin
      if (op.func == spq_pkg::FUNC_ENQ && !full) begin
        count <= count + 1'b1;
      end else if (op.func == spq_pkg::FUNC_DEQ && !empty) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      if (op.func == spq_pkg::FUNC_ENQ) begin
        rsp.out_id   <= '0;
        rsp.out_prio <= '0;
        if (full) begin
          rsp.status    <= spq_pkg::ST_FULL;
          rsp.occupancy <= spq_pkg::OCC_W'(count);
        end else begin
          rsp.status    <= spq_pkg::ST_OK;
          rsp.occupancy <= spq_pkg::OCC_W'(count + 1'b1);
        end
      end else begin
        if (empty) begin
          rsp.status    <= spq_pkg::ST_EMPTY;
          rsp.out_id    <= '0;
          rsp.out_prio  <= '0;
          rsp.occupancy <= spq_pkg::OCC_W'(count);
        end else begin
          rsp.status    <= spq_pkg::ST_OK;
          rsp.out_id    <= cells[0].proc_id;
          rsp.out_prio  <= cells[0].prio;
          rsp.occupancy <= spq_pkg::OCC_W'(count - 1'b1);
        end
      end
    end
  end

endmodule

FILE: design/stable_priority_queue_top.sv
// ----------------------------------------------------------------------------
// stable_priority_queue_top
// Bounded priority queue of process entries, highest priority first and
// first come first served among equal priorities.
// ----------------------------------------------------------------------------
// A request is transferred into the request holding register, and then in an
// execute step the sorted row of entry registers compares every held
// priority against the new one at once and shifts to insert or remove. The
// response then sits in an output register, and the next request is taken
// only after the execute step, so the block does not take a new request
// before it is through with the last one. If a response is still waiting,
// the execute cycle of the next request is held until it has been taken.
// ----------------------------------------------------------------------------
module stable_priority_queue_top (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  spq_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output spq_pkg::rsp_t rsp
);

  spq_pkg::cmd_t cmd;

  spq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .cmd       (cmd)
  );

  spq_datapath u_datapath (
    .clk (clk),
    .rst (rst),
    .cmd (cmd),
    .req (req),
    .rsp (rsp)
  );

endmodule

FILE: design/spq_checker.sv
// ----------------------------------------------------------------------------
// spq_checker
// Port-level checks on the stable priority queue, bound to the top level.
// ----------------------------------------------------------------------------
module spq_checker (
  input logic          clk,
  input logic          rst,
  input logic          req_valid,
  input logic          req_ready,
  input spq_pkg::req_t req,
  input logic          rsp_valid,
  input logic          rsp_ready,
  input spq_pkg::rsp_t rsp
);

  // A waiting request must hold.
  assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_ready |=> req_valid && $stable(req))
    else $error("request changed while waiting");

  // A stalled response must hold.
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("response changed while stalled");

  // Only one request is in flight at a time.
  assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken while another was in flight");

  // A refused enqueue reports a full queue.
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status == spq_pkg::ST_FULL |->
      rsp.occupancy == spq_pkg::OCC_W'(spq_pkg::CAPACITY)
      && rsp.out_id == '0 && rsp.out_prio == '0)
    else $error("full status with wrong occupancy or payload");

  // A dequeue on an empty queue returns nothing and leaves it empty.
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status == spq_pkg::ST_EMPTY |->
      rsp.occupancy == '0 && rsp.out_id == '0 && rsp.out_prio == '0)
    else $error("empty status with non-zero payload");

endmodule

bind stable_priority_queue_top spq_checker u_spq_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_ready (req_ready),
  .req       (req),
  .rsp_valid (rsp_valid),
  .rsp_ready (rsp_ready),
  .rsp       (rsp)
);

FILE: tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the stable priority queue. A queue of requests,
// filled by the stimulus process, feeds a clocked driver. A clocked monitor
// works out each response from its own sorted copy of the queue and checks
// what the block returns.
// ----------------------------------------------------------------------------
module testbench;

  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASE_ITEMS = 400;

  logic clk;
  logic rst       = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  spq_pkg::req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  spq_pkg::rsp_t rsp;

  spq_pkg::req_t   req_backlog[$];
  spq_pkg::rsp_t   due_responses[$];
  spq_pkg::entry_t sorted_slots[spq_pkg::CAPACITY];
  int     sorted_count   = 0;
  int     issued         = 0;
  int     accepted       = 0;
  int     fails          = 0;
  int     cycles         = 0;
  int     send_gap_pct   = 0;
  int     recv_stall_pct = 0;
  logic   req_taken      = 1'b0;
  spq_pkg::rsp_t   want_rsp;

  stable_priority_queue_top i_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
  end

  // A new entry goes behind every held entry of greater or equal priority.
  function automatic spq_pkg::rsp_t ready_queue_step(spq_pkg::req_t r);
    spq_pkg::rsp_t res;
    int   pos;
    res = '0;
    if (r.func == spq_pkg::FUNC_ENQ) begin
      if (sorted_count >= spq_pkg::CAPACITY) begin
        res.status = spq_pkg::ST_FULL;
      end else begin
        res.status = spq_pkg::ST_OK;
        pos = 0;
        while (pos < sorted_count && sorted_slots[pos].prio >= r.prio) pos++;
        for (int i = sorted_count; i > pos; i--) sorted_slots[i] = sorted_slots[i-1];
        sorted_slots[pos].proc_id = r.proc_id;
        sorted_slots[pos].prio    = r.prio;
        sorted_count++;
      end
    end else begin
      if (sorted_count == 0) begin
        res.status = spq_pkg::ST_EMPTY;
      end else begin
        res.status   = spq_pkg::ST_OK;
        res.out_id   = sorted_slots[0].proc_id;
        res.out_prio = sorted_slots[0].prio;
        for (int i = 1; i < sorted_count; i++) sorted_slots[i-1] = sorted_slots[i];
        sorted_count--;
      end
    end
    res.occupancy = spq_pkg::OCC_W'(sorted_count);
    return res;
  endfunction

  task automatic push_item(logic f, logic [7:0] id, logic [7:0] p);
    spq_pkg::req_t r;
    r.func    = f;
    r.proc_id = id;
    r.prio    = p;
    req_backlog.push_back(r);
    issued++;
  endtask

  // Bursts that lean towards enqueue or dequeue, or balance the two, so that the queue
  // swings between empty and full, with priorities often crowded onto a few values.
  task automatic add_random_items(int count);
    int         left;
    int         burst;
    int         enq_pct;
    logic [7:0] p;
    left = count;
    while (left > 0) begin
      burst = $urandom_range(40, 6);
      if (burst > left) burst = left;
      case ($urandom_range(2))
        0:       enq_pct = 75;
        1:       enq_pct = 30;
        default: enq_pct = 50;
      endcase
      repeat (burst) begin
        case ($urandom_range(3))
          0:       p = 8'($urandom_range(255));
          1:       p = 8'($urandom_range(3));
          2:       p = 8'(252 + $urandom_range(3));
          default: p = 8'(16 * $urandom_range(15));
        endcase
        push_item(($urandom_range(99) < enq_pct) ? spq_pkg::FUNC_ENQ : spq_pkg::FUNC_DEQ,
                  8'($urandom_range(255)), p);
      end
      left -= burst;
    end
  endtask

  always @(negedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (!req_valid || req_taken) begin
      if (req_backlog.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
        req       <= req_backlog.pop_front();
        req_valid <= 1'b1;
      end else begin
        req_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    rsp_ready <= !rst && ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (req_valid && req_ready) begin
        due_responses.push_back(ready_queue_step(req));
        accepted++;
      end
      if (rsp_valid && rsp_ready) begin
        if (due_responses.size() == 0) begin
          $error("response transfer with no request outstanding");
          fails++;
        end else begin
          want_rsp = due_responses.pop_front();
          if (rsp.status !== want_rsp.status) begin
            $error("status: expected %0d, got %0d", want_rsp.status, rsp.status);
            fails++;
          end
          if (rsp.out_id !== want_rsp.out_id) begin
            $error("out_id: expected %0d, got %0d", want_rsp.out_id, rsp.out_id);
            fails++;
          end
          if (rsp.out_prio !== want_rsp.out_prio) begin
            $error("out_prio: expected %0d, got %0d", want_rsp.out_prio, rsp.out_prio);
            fails++;
          end
          if (rsp.occupancy !== want_rsp.occupancy) begin
            $error("occupancy: expected %0d, got %0d", want_rsp.occupancy,
                   rsp.occupancy);
            fails++;
          end
        end
      end
    end
    req_taken <= !rst && req_valid && req_ready;
  end

  initial begin
    send_gap_pct   = 21;
    recv_stall_pct = 85;

    // Dequeue from an empty queue, fill it with ties and extremes, overflow
    // it once, then take a few entries from the head.
    push_item(spq_pkg::FUNC_DEQ, 8'hFF, 8'hFF);
    for (int k = 0; k < spq_pkg::CAPACITY; k++) begin
      case (k % 4)
        0:       push_item(spq_pkg::FUNC_ENQ, (k == 0) ? 8'h00 : 8'(k * 13), 8'hFF);
        1:       push_item(spq_pkg::FUNC_ENQ, (k == 1) ? 8'hFF : 8'(k * 13), 8'h00);
        default: push_item(spq_pkg::FUNC_ENQ, 8'(k * 13), 8'h80);
      endcase
    end
    push_item(spq_pkg::FUNC_ENQ, 8'hA5, 8'hFF);
    repeat (4) push_item(spq_pkg::FUNC_DEQ, 8'h00, 8'h00);

    add_random_items(PHASE_ITEMS);
    wait (accepted == issued);
    send_gap_pct   = 85;
    recv_stall_pct = 21;
    add_random_items(PHASE_ITEMS);
    wait (accepted == issued);
    send_gap_pct   = 0;
    recv_stall_pct = 0;
    add_random_items(PHASE_ITEMS);

    do @(negedge clk); while (accepted != issued || due_responses.size() != 0);
    repeat (20) @(negedge clk);
    if (fails == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
